// File: rtl/slpc_pkg.sv
// Shared types and constants for the stereo linked peak compressor.
// Used by the back part and the top level; depends on nothing.
package slpc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOPE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAKEUP    = 3'd4;

    localparam logic signed [15:0] THRESHOLD_RESET = -16'sd5120;
    localparam logic [15:0]        SLOPE_RESET     = 16'd49152;
    localparam logic [23:0]        ATTACK_RESET    = 24'd16742299;
    localparam logic [23:0]        RELEASE_RESET   = 24'd16773721;
    localparam logic [12:0]        MAKEUP_RESET    = 13'd0;

    localparam logic [31:0] DB_PER_LOG2_Q16 = 32'd394566;
    localparam logic [31:0] LOG2_PER_DB_Q16 = 32'd10885;

    localparam logic [31:0] EXP_TAB [16] = '{
        32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
        32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033,
        32'd1075196443, 32'd1074468888, 32'd1074105294, 32'd1073923544,
        32'd1073832680, 32'd1073787251, 32'd1073764537, 32'd1073753181
    };

    typedef struct packed {
        logic signed [15:0] thresh_level;
        logic [15:0]        slope;
        logic [23:0]        attack_coeff;
        logic [23:0]        release_coeff;
        logic [12:0]        makeup_gain;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic done;
    } status_t;

endpackage

// File: rtl/slpc_in_if.sv
// Input channel of the compressor: one stereo pair per item.
// Depends on nothing.
interface slpc_in_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// File: rtl/slpc_out_if.sv
// Output channel of the compressor: one scaled stereo pair per item.
// Depends on nothing.
interface slpc_out_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// File: rtl/slpc_queue.sv
// Two-entry queue between the front and back parts of the compressor.
// Depends on nothing.
module slpc_queue #(
    parameter int WIDTH = 72
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

// File: rtl/slpc_front.sv
// Front part: takes input items, finds the linked peak and queues the item.
// Depends on slpc_in_if.
module slpc_front #(
    parameter int SAMPLE_BITS = 24
) (
    slpc_in_if.sink                  in_ch,
    output logic                     push_valid,
    input  logic                     push_ready,
    output logic [3*SAMPLE_BITS-1:0] push_data
);
    logic [SAMPLE_BITS-1:0] mag_l;
    logic [SAMPLE_BITS-1:0] mag_r;
    logic [SAMPLE_BITS-1:0] peak;

    always_comb
    begin
        mag_l = in_ch.left_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_ch.left_in)
                                             : SAMPLE_BITS'(in_ch.left_in);
        mag_r = in_ch.right_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_ch.right_in)
                                              : SAMPLE_BITS'(in_ch.right_in);
        peak  = (mag_l > mag_r) ? mag_l : mag_r;
    end

    assign push_valid  = in_ch.valid;
    assign in_ch.ready = push_ready;
    assign push_data   = {in_ch.left_in, in_ch.right_in, peak};
endmodule

// File: rtl/slpc_back.sv
// Back part: envelope, level in dB, gain computer and output scaling.
// Depends on slpc_pkg and slpc_out_if; one shared 32x32 multiplier.
module slpc_back #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  slpc_pkg::cfg_t           cfg,
    input  logic                     pop_valid,
    output logic                     pop_ready,
    input  logic [3*SAMPLE_BITS-1:0] pop_data,
    slpc_out_if.source               out_ch,
    output slpc_pkg::status_t        status
);
    import slpc_pkg::*;

    localparam int SB       = SAMPLE_BITS;
    localparam int ENV_FRAC = 32 - SAMPLE_BITS;

    typedef enum logic [17:0] {
        S_IDLE = 18'h00001,
        S_ENV0 = 18'h00002,
        S_ENV1 = 18'h00004,
        S_ENV2 = 18'h00008,
        S_NORM = 18'h00010,
        S_LOGI = 18'h00020,
        S_LOG  = 18'h00040,
        S_DB   = 18'h00080,
        S_RED  = 18'h00100,
        S_RMUL = 18'h00200,
        S_GAIN = 18'h00400,
        S_EXP0 = 18'h00800,
        S_EXP1 = 18'h01000,
        S_EXPL = 18'h02000,
        S_SCL0 = 18'h04000,
        S_SCL1 = 18'h08000,
        S_SCL2 = 18'h10000,
        S_DONE = 18'h20000
    } state_t;

    function automatic logic [SB-1:0] mag_of(input logic signed [SB-1:0] x);
        mag_of = x[SB-1] ? SB'(-x) : SB'(x);
    endfunction

    function automatic logic [SB-1:0] finish(input logic neg, input logic [63:0] p,
                                             input logic signed [9:0] ip);
        logic signed [10:0] sh;
        logic [5:0]         shu;
        logic [63:0]        q;
        logic [63:0]        hi;
        sh  = 11'sd30 - 11'(ip);
        shu = sh[5:0];
        hi  = (64'd1 << (SB - 1)) - 64'd1;
        if (sh >= 11'sd63)
        begin
            q = 64'd0;
        end
        else if (sh > 11'sd0)
        begin
            q = (p + (64'd1 << (shu - 6'd1))) >> shu;
        end
        else
        begin
            q = p;
        end
        if (q > (64'd1 << 33))
        begin
            q = 64'd1 << 33;
        end
        if (neg)
        begin
            if (q > hi + 64'd1)
            begin
                q = hi + 64'd1;
            end
            finish = SB'(-q);
        end
        else
        begin
            if (q > hi)
            begin
                q = hi;
            end
            finish = SB'(q);
        end
    endfunction

    state_t                 state_reg;
    logic [31:0]            env_reg;
    logic signed [SB-1:0]   l_reg;
    logic signed [SB-1:0]   r_reg;
    logic [31:0]            peak_reg;
    logic [23:0]            c_reg;
    logic [63:0]            p_reg;
    logic [63:0]            s_reg;
    logic [31:0]            norm_reg;
    logic [4:0]             z_reg;
    logic [3:0]             cnt_reg;
    logic [30:0]            m_reg;
    logic [15:0]            frac_reg;
    logic                   red_reg;
    logic [16:0]            diff_reg;
    logic signed [18:0]     g_reg;
    logic signed [9:0]      ip_reg;
    logic [15:0]            f_reg;
    logic [30:0]            acc_reg;
    logic [SB-1:0]          lo_reg;
    logic [SB-1:0]          ro_reg;
    logic                   out_valid_reg;
    logic [SB-1:0]          out_l_reg;
    logic [SB-1:0]          out_r_reg;

    logic [23:0]        c_sel;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod;
    logic [57:0]        env_sum;
    logic [4:0]         sa;
    logic [31:0]        top_bits;
    logic [31:0]        sq;
    logic [20:0]        nl;
    logic [40:0]        db_sum;
    logic signed [17:0] env_db;
    logic signed [17:0] thr_ext;
    logic [33:0]        red_sum;
    logic [17:0]        gmag;
    logic [32:0]        e_sum;
    logic signed [25:0] e_val;

    always_comb
    begin
        c_sel    = (peak_reg > env_reg) ? cfg.attack_coeff : cfg.release_coeff;
        env_sum  = s_reg[57:0] + p_reg[57:0] + 58'd8388608;
        sa       = 5'd16 >> cnt_reg[2:0];
        top_bits = norm_reg >> (6'd32 - {1'b0, sa});
        nl       = {z_reg, 16'd0} - {5'd0, frac_reg};
        db_sum   = {1'b0, p_reg[39:0]} + 41'd8388608;
        env_db   = -$signed({2'b00, db_sum[39:24]});
        thr_ext  = 18'(cfg.thresh_level);
        red_sum  = p_reg[33:0] + 34'd32768;
        gmag     = g_reg[18] ? 18'(-g_reg) : 18'(g_reg);
        e_sum    = {1'b0, p_reg[31:0]} + 33'd128;
        e_val    = g_reg[18] ? -$signed({1'b0, e_sum[32:8]}) : $signed({1'b0, e_sum[32:8]});
        mul_a    = 32'd0;
        mul_b    = 32'd0;
        case (state_reg)
            S_ENV0:
            begin
                mul_a = 32'(c_sel);
                mul_b = env_reg;
            end
            S_ENV1:
            begin
                mul_a = 32'(25'h1000000 - {1'b0, c_reg});
                mul_b = peak_reg;
            end
            S_LOG:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            S_DB:
            begin
                mul_a = 32'(nl);
                mul_b = DB_PER_LOG2_Q16;
            end
            S_RMUL:
            begin
                mul_a = 32'(diff_reg);
                mul_b = 32'(cfg.slope);
            end
            S_EXP0:
            begin
                mul_a = 32'(gmag);
                mul_b = LOG2_PER_DB_Q16;
            end
            S_EXPL:
            begin
                mul_a = {1'b0, acc_reg};
                mul_b = EXP_TAB[cnt_reg];
            end
            S_SCL0:
            begin
                mul_a = 32'(mag_of(l_reg));
                mul_b = {1'b0, acc_reg};
            end
            S_SCL1:
            begin
                mul_a = 32'(mag_of(r_reg));
                mul_b = {1'b0, acc_reg};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
        prod = mul_a * mul_b;
        sq   = prod[61:30];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                l_reg    <= pop_data[3*SB-1:2*SB];
                r_reg    <= pop_data[2*SB-1:SB];
                peak_reg <= 32'(pop_data[SB-1:0]) << ENV_FRAC;
            end
            S_ENV0:
            begin
                c_reg <= c_sel;
                p_reg <= prod;
            end
            S_ENV1:
            begin
                s_reg <= p_reg;
                p_reg <= prod;
            end
            S_ENV2:
            begin
                norm_reg <= env_sum[55:24];
                z_reg    <= 5'd0;
                cnt_reg  <= 4'd0;
                red_reg  <= 1'b0;
            end
            S_NORM:
            begin
                if (top_bits == 32'd0)
                begin
                    norm_reg <= norm_reg << sa;
                    z_reg    <= z_reg + sa;
                end
                cnt_reg <= (cnt_reg == 4'd4) ? 4'd0 : cnt_reg + 4'd1;
            end
            S_LOGI:
            begin
                m_reg    <= norm_reg[31:1];
                frac_reg <= 16'd0;
            end
            S_LOG:
            begin
                frac_reg <= {frac_reg[14:0], sq[31]};
                m_reg    <= sq[31] ? sq[31:1] : sq[30:0];
                cnt_reg  <= cnt_reg + 4'd1;
            end
            S_DB:
            begin
                p_reg <= prod;
            end
            S_RED:
            begin
                red_reg  <= (env_db > thr_ext);
                diff_reg <= 17'(env_db - thr_ext);
            end
            S_RMUL:
            begin
                p_reg <= prod;
            end
            S_GAIN:
            begin
                g_reg <= $signed({6'd0, cfg.makeup_gain})
                       - (red_reg ? $signed({1'b0, red_sum[33:16]}) : 19'sd0);
            end
            S_EXP0:
            begin
                p_reg <= prod;
            end
            S_EXP1:
            begin
                ip_reg  <= e_val[25:16];
                f_reg   <= e_val[15:0];
                acc_reg <= 31'h40000000;
                cnt_reg <= 4'd0;
            end
            S_EXPL:
            begin
                if (f_reg[4'd15 - cnt_reg])
                begin
                    acc_reg <= 31'((prod + 64'h20000000) >> 30);
                end
                cnt_reg <= cnt_reg + 4'd1;
            end
            S_SCL0:
            begin
                p_reg <= prod;
            end
            S_SCL1:
            begin
                lo_reg <= finish(l_reg[SB-1], p_reg, ip_reg);
                p_reg  <= prod;
            end
            S_SCL2:
            begin
                ro_reg <= finish(r_reg[SB-1], p_reg, ip_reg);
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_DONE && (!out_valid_reg || out_ch.ready))
        begin
            out_l_reg <= lo_reg;
            out_r_reg <= ro_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            env_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && (!out_valid_reg || out_ch.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        state_reg <= S_ENV0;
                    end
                end
                S_ENV0: state_reg <= S_ENV1;
                S_ENV1: state_reg <= S_ENV2;
                S_ENV2:
                begin
                    env_reg   <= env_sum[55:24];
                    state_reg <= (env_sum[55:24] == 32'd0) ? S_GAIN : S_NORM;
                end
                S_NORM:
                begin
                    if (cnt_reg == 4'd4)
                    begin
                        state_reg <= S_LOGI;
                    end
                end
                S_LOGI: state_reg <= S_LOG;
                S_LOG:
                begin
                    if (cnt_reg == 4'd15)
                    begin
                        state_reg <= S_DB;
                    end
                end
                S_DB:   state_reg <= S_RED;
                S_RED:  state_reg <= S_RMUL;
                S_RMUL: state_reg <= S_GAIN;
                S_GAIN: state_reg <= S_EXP0;
                S_EXP0: state_reg <= S_EXP1;
                S_EXP1: state_reg <= S_EXPL;
                S_EXPL:
                begin
                    if (cnt_reg == 4'd15)
                    begin
                        state_reg <= S_SCL0;
                    end
                end
                S_SCL0: state_reg <= S_SCL1;
                S_SCL1: state_reg <= S_SCL2;
                S_SCL2: state_reg <= S_DONE;
                S_DONE:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign pop_ready        = (state_reg == S_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.left_out  = out_l_reg;
    assign out_ch.right_out = out_r_reg;
    assign status.idle      = (state_reg == S_IDLE);
    assign status.done      = (state_reg == S_DONE);
endmodule

// File: rtl/stereo_linked_peak_compressor_top.sv
// Top level of the stereo linked peak compressor: configuration registers,
// front part, queue and back part. Depends on slpc_pkg, the interfaces and submodules.
//
// Channel   Direction  Handshake      Payload
// in_ch     in         valid/ready    left_in, right_in
// out_ch    out        valid/ready    left_out, right_out
// cfg       in         cfg_we         cfg_index, cfg_data
//
// The back part takes one item at a time from the queue and takes no new one until
// the result has moved to the output register; a zero envelope skips the
// normalisation and log steps. The shared multiplier runs the 16-step log loop and
// the 16-step exponent loop. Reset clears the envelope and loads the register
// defaults. Two items can wait in the queue while the back part is busy, and a
// finished item waits in the output register until it is taken.
module stereo_linked_peak_compressor_top #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    slpc_in_if.sink                           in_ch,
    slpc_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [slpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [slpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import slpc_pkg::*;

    localparam int ENTRY_W = 3 * SAMPLE_BITS;

    cfg_t               cfg_reg;
    status_t            status;
    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thresh_level  <= THRESHOLD_RESET;
            cfg_reg.slope         <= SLOPE_RESET;
            cfg_reg.attack_coeff  <= ATTACK_RESET;
            cfg_reg.release_coeff <= RELEASE_RESET;
            cfg_reg.makeup_gain   <= MAKEUP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD: cfg_reg.thresh_level  <= $signed(cfg_data[15:0]);
                CFG_SLOPE:     cfg_reg.slope         <= cfg_data[15:0];
                CFG_ATTACK:    cfg_reg.attack_coeff  <= cfg_data[23:0];
                CFG_RELEASE:   cfg_reg.release_coeff <= cfg_data[23:0];
                CFG_MAKEUP:    cfg_reg.makeup_gain   <= cfg_data[12:0];
                default:
                begin
                end
            endcase
        end
    end

    slpc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    slpc_queue #(.WIDTH(ENTRY_W)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    slpc_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_ch    (out_ch),
        .status    (status)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |-> status.idle)
        else $error("queue popped while the back part was busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> pop_valid)
        else $error("input stalled with an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (status.done && !out_ch.valid) |=> out_ch.valid)
        else $error("finished item not moved to the output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(status.done))
        else $error("output became valid without a finished item");
endmodule
